// ===== rtl/bfhs_pkg.sv =====
// Shared types, phase codes and status codes for the bit file header stripper.
// Used by every module of the block; depends on nothing.

package bfhs_pkg;

    // one input beat
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    // one result beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [34:0] length_bits;
        logic        last;
    } out_item_t;

    // work passed from the parser to the output side: what one input byte produced
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        stat_valid;
        logic [1:0]  status;
        logic [34:0] length_bits;
    } work_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // parser phases
    localparam logic [3:0] PH_F1_HI   = 4'd0;
    localparam logic [3:0] PH_F1_LO   = 4'd1;
    localparam logic [3:0] PH_F1_BODY = 4'd2;
    localparam logic [3:0] PH_F2_HI   = 4'd3;
    localparam logic [3:0] PH_F2_LO   = 4'd4;
    localparam logic [3:0] PH_TYPE    = 4'd5;
    localparam logic [3:0] PH_LEN_HI  = 4'd6;
    localparam logic [3:0] PH_LEN_LO  = 4'd7;
    localparam logic [3:0] PH_BODY    = 4'd8;
    localparam logic [3:0] PH_SIZE    = 4'd9;
    localparam logic [3:0] PH_PAYLOAD = 4'd10;
    localparam logic [3:0] PH_TRAIL   = 4'd11;

    localparam logic [7:0] TYPE_SIZE_FIELD = 8'h65;
    localparam logic [1:0] SIZE_BYTES_LAST = 2'd3;

    localparam logic [1:0] ST_EXACT   = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_REVERSE_BITS = 1'b0;

    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/bfhs_front.sv =====
// Header parser: walks the file header one byte per beat and emits work entries.
// Depends on bfhs_pkg.

module bfhs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bfhs_pkg::in_item_t  item,
    input  logic                reverse_bits,
    output logic                push,
    output bfhs_pkg::work_t     work
);
    import bfhs_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] field_length_reg, field_length_next;
    logic [15:0] skip_reg, skip_next;
    logic [1:0]  size_seen_reg, size_seen_next;
    logic [31:0] declared_reg, declared_next;
    logic [31:0] remaining_reg, remaining_next;

    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] skip_dec;
    logic [31:0] rem_dec;
    logic        dropped;

    assign b        = item.file_byte;
    assign len      = {field_length_reg[7:0], b};
    assign skip_dec = skip_reg - 16'd1;
    assign rem_dec  = remaining_reg - 32'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        field_length_next = field_length_reg;
        skip_next         = skip_reg;
        size_seen_next    = size_seen_reg;
        declared_next     = declared_reg;
        remaining_next    = remaining_reg;
        dropped           = 1'b0;
        work              = '0;

        case (phase_reg)
            PH_F1_LO:
            begin
                skip_next  = len;
                phase_next = (len == 16'd0) ? PH_F2_HI : PH_F1_BODY;
            end
            PH_F1_BODY:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_F2_HI;
                end
            end
            PH_F2_HI:
            begin
                field_length_next = {8'd0, b};
                phase_next        = PH_F2_LO;
            end
            PH_F2_LO:
            begin
                field_length_next = len;
                phase_next        = PH_TYPE;
            end
            PH_TYPE:
            begin
                if (b == TYPE_SIZE_FIELD)
                begin
                    size_seen_next = 2'd0;
                    declared_next  = 32'd0;
                    phase_next     = PH_SIZE;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                field_length_next = {8'd0, b};
                phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                field_length_next = len;
                skip_next         = len;
                phase_next        = (len == 16'd0) ? PH_TYPE : PH_BODY;
            end
            PH_BODY:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_SIZE:
            begin
                declared_next = {declared_reg[23:0], b};
                if (size_seen_reg == SIZE_BYTES_LAST)
                begin
                    size_seen_next = 2'd0;
                    remaining_next = declared_next;
                    phase_next     = (declared_next == 32'd0) ? PH_TRAIL : PH_PAYLOAD;
                end
                else
                begin
                    size_seen_next = size_seen_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                work.pay_valid = 1'b1;
                work.pay_byte  = reverse_bits ? flip_byte(b) : b;
                remaining_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                dropped = 1'b1;
            end
            default:
            begin
                field_length_next = {8'd0, b};
                phase_next        = PH_F1_LO;
            end
        endcase

        if (item.end_of_file)
        begin
            work.stat_valid  = 1'b1;
            work.length_bits = {declared_next, 3'b000};
            if (dropped)
            begin
                work.status = ST_DROPPED;
            end
            else if (phase_next == PH_TRAIL)
            begin
                work.status = ST_EXACT;
            end
            else if (phase_next == PH_PAYLOAD)
            begin
                work.status = ST_SHORT;
            end
            else
            begin
                work.status      = ST_TRUNC;
                work.length_bits = '0;
            end
            // start over for the next file
            phase_next        = PH_F1_HI;
            field_length_next = 16'd0;
            skip_next         = 16'd0;
            size_seen_next    = 2'd0;
            declared_next     = 32'd0;
            remaining_next    = 32'd0;
        end
    end

    assign push = accept && (work.pay_valid || work.stat_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_F1_HI;
            field_length_reg <= 16'd0;
            skip_reg         <= 16'd0;
            size_seen_reg    <= 2'd0;
            declared_reg     <= 32'd0;
            remaining_reg    <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            field_length_reg <= field_length_next;
            skip_reg         <= skip_next;
            size_seen_reg    <= size_seen_next;
            declared_reg     <= declared_next;
            remaining_reg    <= remaining_next;
        end
    end

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_file |=> phase_reg == PH_F1_HI && declared_reg == 32'd0)
        else $error("parser did not restart after end of file");

    a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        push && work.pay_valid |-> phase_reg == PH_PAYLOAD && remaining_reg != 32'd0)
        else $error("payload emitted outside the payload phase");

endmodule

// ===== rtl/bfhs_queue.sv =====
// Short work queue between the parser and the output side.
// Depends on bfhs_pkg.

module bfhs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bfhs_pkg::work_t  push_work,
    input  logic             pop,
    output bfhs_pkg::work_t  head,
    output logic             empty,
    output logic             full
);
    import bfhs_pkg::*;

    work_t               slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/bfhs_back.sv =====
// Output side: turns queued work into result beats through an output register.
// Depends on bfhs_pkg.

module bfhs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfhs_pkg::work_t      head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bfhs_pkg::out_item_t  out_item
);
    import bfhs_pkg::*;

    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        pend_valid_reg;
    logic [1:0]  pend_status_reg;
    logic [34:0] pend_len_reg;
    logic        load;

    assign load      = !out_valid_reg || !out_stall;
    assign pop       = load && !pend_valid_reg && !empty;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= '{kind: KIND_STATUS, payload_byte: 8'd0,
                             status: pend_status_reg, length_bits: pend_len_reg,
                             last: 1'b1};
            end
            else if (head.pay_valid)
            begin
                out_reg <= '{kind: KIND_PAYLOAD, payload_byte: head.pay_byte,
                             status: ST_EXACT, length_bits: 35'd0, last: 1'b0};
            end
            else
            begin
                out_reg <= '{kind: KIND_STATUS, payload_byte: 8'd0,
                             status: head.status, length_bits: head.length_bits,
                             last: 1'b1};
            end
        end
        if (pop)
        begin
            pend_status_reg <= head.status;
            pend_len_reg    <= head.length_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= pend_valid_reg || !empty;
            // hold the status of an end-of-file payload byte for the next beat
            pend_valid_reg <= pop && head.pay_valid && head.stat_valid;
        end
    end

    a_pend_behind_payload: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg && out_reg.kind == KIND_PAYLOAD)
        else $error("held status without a payload beat ahead of it");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.last == (out_reg.kind == KIND_STATUS))
        else $error("last flag does not match result kind");

endmodule

// ===== rtl/bit_file_header_stripper_unit.sv =====
// Top level of the bit file header stripper: APB register, parser, queue, output side.
// Depends on bfhs_pkg, bfhs_front, bfhs_queue, bfhs_back.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------
//  bytes in  | byte_valid / byte_stall     | byte_item   (in_item_t)
//  results   | result_valid / result_stall | result_item (out_item_t)
//  registers | APB psel/penable/pwrite     | paddr[2:0], pwdata, prdata
//
// One byte is taken every cycle unless byte_stall is high; a taken payload byte is queued,
// then registered as a result beat. An end-of-file byte inside the payload gives two beats.
// byte_stall rises only when the four-entry work queue is full, i.e. when result_stall
// has held the output long enough to back up the queue.
// Reset clears the parser, the queue and reverse_bits; a file may start at once.

module bit_file_header_stripper_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  bfhs_pkg::in_item_t   byte_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output bfhs_pkg::out_item_t  result_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bfhs_pkg::*;

    logic  reverse_bits_reg;
    logic  accept;
    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    work_t push_work;
    work_t head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REVERSE_BITS) ? {31'd0, reverse_bits_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_bits_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_REVERSE_BITS)
        begin
            reverse_bits_reg <= pwdata[0];
        end
    end

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    bfhs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (byte_item),
        .reverse_bits (reverse_bits_reg),
        .push         (push),
        .work         (push_work)
    );

    bfhs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    bfhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_item  (result_item)
    );

endmodule
